[hdl/jsp_pkg.sv]
package jsp_pkg;

    // Request on the input side: one byte of document text.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_req;

    // Request on the result side.
    typedef struct packed {
        logic       result_kind;
        logic [7:0] decoded_char;
        logic [2:0] parse_status;
        logic [1:0] value_kind;
        logic       bool_value;
    } t_out_req;

    // A byte after classification by the front part.
    typedef struct packed {
        logic       is_end;
        logic [7:0] text_byte;
        logic       is_space;
        logic       is_quote;
        logic       is_bslash;
        logic       is_ctrl;
        logic       lit_start;
        logic [1:0] lit_kind;
        logic       esc_ok;
        logic [7:0] esc_char;
    } t_cmd;

    localparam int unsigned CMD_W = $bits(t_cmd);
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic       RK_CHAR   = 1'b0;
    localparam logic       RK_STATUS = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_EXPECT     = 3'd1;
    localparam logic [2:0] ST_INVALID    = 3'd2;
    localparam logic [2:0] ST_NOT_SINGLE = 3'd3;
    localparam logic [2:0] ST_MISS_QUOTE = 3'd4;
    localparam logic [2:0] ST_BAD_ESCAPE = 3'd5;
    localparam logic [2:0] ST_BAD_CHAR   = 3'd6;

    localparam logic [1:0] VK_NULL   = 2'd0;
    localparam logic [1:0] VK_BOOL   = 2'd1;
    localparam logic [1:0] VK_STRING = 2'd2;

    localparam logic [1:0] LK_NULL  = 2'd0;
    localparam logic [1:0] LK_TRUE  = 2'd1;
    localparam logic [1:0] LK_FALSE = 2'd2;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Expected byte of a literal at a given position.
    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (kind)
            LK_TRUE: begin
                case (pos)
                    3'd0: ch = "t";
                    3'd1: ch = "r";
                    3'd2: ch = "u";
                    3'd3: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            LK_FALSE: begin
                case (pos)
                    3'd0: ch = "f";
                    3'd1: ch = "a";
                    3'd2: ch = "l";
                    3'd3: ch = "s";
                    3'd4: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            default: begin
                case (pos)
                    3'd0: ch = "n";
                    3'd1: ch = "u";
                    3'd2: ch = "l";
                    3'd3: ch = "l";
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        return (kind == LK_FALSE) ? 3'd5 : 3'd4;
    endfunction

endpackage

[hdl/jsp_front.sv]
module jsp_front
    import jsp_pkg::*;
(
    input  t_in_req i_req,
    output t_cmd    o_cmd
);

    logic [7:0] b;

    assign b = i_req.text_byte;

    always_comb begin
        o_cmd           = '0;
        // A zero byte terminates the document just like the end marker.
        o_cmd.is_end    = i_req.end_of_text || (b == 8'h00);
        o_cmd.text_byte = b;
        o_cmd.is_space  = (b == CH_SPACE) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
        o_cmd.is_quote  = (b == CH_QUOTE);
        o_cmd.is_bslash = (b == CH_BSLASH);
        o_cmd.is_ctrl   = (b < CH_SPACE);
        o_cmd.lit_start = 1'b1;
        case (b)
            "n":     o_cmd.lit_kind = LK_NULL;
            "t":     o_cmd.lit_kind = LK_TRUE;
            "f":     o_cmd.lit_kind = LK_FALSE;
            default: begin
                o_cmd.lit_kind  = LK_NULL;
                o_cmd.lit_start = 1'b0;
            end
        endcase
        o_cmd.esc_ok = 1'b1;
        case (b)
            CH_QUOTE:  o_cmd.esc_char = CH_QUOTE;
            CH_BSLASH: o_cmd.esc_char = CH_BSLASH;
            "/":       o_cmd.esc_char = "/";
            "b":       o_cmd.esc_char = 8'h08;
            "f":       o_cmd.esc_char = 8'h0C;
            "n":       o_cmd.esc_char = 8'h0A;
            "r":       o_cmd.esc_char = 8'h0D;
            "t":       o_cmd.esc_char = 8'h09;
            default: begin
                o_cmd.esc_char = 8'h00;
                o_cmd.esc_ok   = 1'b0;
            end
        endcase
    end

endmodule

[hdl/jsp_queue.sv]
module jsp_queue
    import jsp_pkg::*;
#(
    parameter int unsigned Depth = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_rd,
    output t_cmd o_data,
    output logic o_empty
);

    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CW = $clog2(Depth + 1);
    localparam logic [AW-1:0] LAST = AW'(Depth - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

    t_cmd          r_mem [Depth];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          wr_en;
    logic          rd_en;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + AW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

[hdl/jsp_back.sv]
module jsp_back
    import jsp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cmd     i_cmd,
    input  logic     i_cmd_empty,
    output logic     o_cmd_rd,
    output t_out_req o_result,
    output logic     o_empty,
    input  logic     i_pop
);

    localparam logic [2:0] PH_START   = 3'd0;
    localparam logic [2:0] PH_LITERAL = 3'd1;
    localparam logic [2:0] PH_STRING  = 3'd2;
    localparam logic [2:0] PH_ESCAPE  = 3'd3;
    localparam logic [2:0] PH_TRAIL   = 3'd4;
    localparam logic [2:0] PH_ERROR   = 3'd5;

    logic [2:0] r_phase, n_phase;
    logic [2:0] r_lit_pos, n_lit_pos;
    logic [1:0] r_lit_kind, n_lit_kind;
    logic [2:0] r_status, n_status;
    logic [1:0] r_vkind, n_vkind;
    logic       r_bool, n_bool;
    t_out_req   r_out, n_out;
    logic       r_out_valid;
    logic       emit;
    logic       take;
    logic [2:0] end_st;

    // The output register frees up in the same cycle that its request is popped.
    assign take     = !i_cmd_empty && (!r_out_valid || i_pop);
    assign o_cmd_rd = take;
    assign o_result = r_out;
    assign o_empty  = !r_out_valid;

    always_comb begin
        case (r_phase)
            PH_START:   end_st = ST_EXPECT;
            PH_LITERAL: end_st = ST_INVALID;
            PH_STRING:  end_st = ST_MISS_QUOTE;
            PH_ESCAPE:  end_st = ST_BAD_ESCAPE;
            PH_TRAIL:   end_st = ST_OK;
            default:    end_st = r_status;
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_lit_pos  = r_lit_pos;
        n_lit_kind = r_lit_kind;
        n_status   = r_status;
        n_vkind    = r_vkind;
        n_bool     = r_bool;
        n_out      = '0;
        emit       = 1'b0;
        if (i_cmd.is_end) begin
            emit                = 1'b1;
            n_out.result_kind   = RK_STATUS;
            n_out.parse_status  = end_st;
            n_out.value_kind    = (end_st == ST_OK) ? r_vkind : VK_NULL;
            n_out.bool_value    = (end_st == ST_OK) && (r_vkind == VK_BOOL) && r_bool;
            n_phase    = PH_START;
            n_lit_pos  = '0;
            n_lit_kind = LK_NULL;
            n_status   = ST_OK;
            n_vkind    = VK_NULL;
            n_bool     = 1'b0;
        end else begin
            case (r_phase)
                PH_START: begin
                    if (i_cmd.lit_start) begin
                        n_lit_kind = i_cmd.lit_kind;
                        n_lit_pos  = 3'd1;
                        n_phase    = PH_LITERAL;
                    end else if (i_cmd.is_quote) begin
                        n_phase = PH_STRING;
                    end else begin
                        n_status = ST_INVALID;
                        n_phase  = PH_ERROR;
                    end
                end
                PH_LITERAL: begin
                    if (i_cmd.text_byte != lit_char(r_lit_kind, r_lit_pos)) begin
                        n_status = ST_INVALID;
                        n_phase  = PH_ERROR;
                    end else begin
                        n_lit_pos = r_lit_pos + 3'd1;
                        if (n_lit_pos >= lit_len(r_lit_kind)) begin
                            n_vkind = (r_lit_kind == LK_NULL) ? VK_NULL : VK_BOOL;
                            n_bool  = (r_lit_kind == LK_TRUE);
                            n_phase = PH_TRAIL;
                        end
                    end
                end
                PH_STRING: begin
                    if (i_cmd.is_quote) begin
                        n_vkind = VK_STRING;
                        n_bool  = 1'b0;
                        n_phase = PH_TRAIL;
                    end else if (i_cmd.is_bslash) begin
                        n_phase = PH_ESCAPE;
                    end else if (i_cmd.is_ctrl) begin
                        n_status = ST_BAD_CHAR;
                        n_phase  = PH_ERROR;
                    end else begin
                        emit               = 1'b1;
                        n_out.result_kind  = RK_CHAR;
                        n_out.decoded_char = i_cmd.text_byte;
                    end
                end
                PH_ESCAPE: begin
                    if (i_cmd.esc_ok) begin
                        emit               = 1'b1;
                        n_out.result_kind  = RK_CHAR;
                        n_out.decoded_char = i_cmd.esc_char;
                        n_phase            = PH_STRING;
                    end else begin
                        n_status = ST_BAD_ESCAPE;
                        n_phase  = PH_ERROR;
                    end
                end
                PH_TRAIL: begin
                    if (!i_cmd.is_space) begin
                        n_status = ST_NOT_SINGLE;
                        n_phase  = PH_ERROR;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_lit_pos   <= '0;
            r_lit_kind  <= LK_NULL;
            r_status    <= ST_OK;
            r_vkind     <= VK_NULL;
            r_bool      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_phase    <= n_phase;
                r_lit_pos  <= n_lit_pos;
                r_lit_kind <= n_lit_kind;
                r_status   <= n_status;
                r_vkind    <= n_vkind;
                r_bool     <= n_bool;
            end
            if (take && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[hdl/json_scalar_byte_parser_top.sv]
// Byte-serial parser for one JSON scalar document: null, true, false or a quoted
// string with the simple escapes. Bytes enter through a queue-style port (push/full)
// and one byte per clock is accepted while the internal queue has room. A front
// stage classifies each byte and writes it into a small queue; a back stage runs the
// parser state machine at one byte per clock while its output register is free or
// being popped, and places any result in that register, read through empty/pop.
// String characters come out as they are decoded, and the end marker (or a zero
// byte) yields the final status request, after which the parser is ready for a new
// document. Sustained rate is one byte per cycle while results are popped in time;
// a result passes through the queue and the output register before it is visible.
// The first error is latched and later bytes give nothing until the end marker.
module json_scalar_byte_parser_top
    import jsp_pkg::*;
#(
    parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_req  i_item,
    output logic     empty,
    input  logic     pop,
    output t_out_req o_result
);

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_empty;
    logic queue_rd;

    // Classification is purely combinational on the incoming request.
    jsp_front u_front (
        .i_req (i_item),
        .o_cmd (front_cmd)
    );

    // The queue lets the input side keep pushing while a result waits to be popped.
    jsp_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_rd    (queue_rd),
        .o_data  (queue_cmd),
        .o_empty (queue_empty)
    );

    // The back stage holds the document state and the output register.
    jsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_cmd_empty (queue_empty),
        .o_cmd_rd    (queue_rd),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule
